FILE: src/wsfd_pkg.sv
// Shared types and constants for the websocket frame deframer.
`default_nettype none

package wsfd_pkg;

   localparam int LENGTH_BITS = 63;
   localparam int LEN_REG_W   = 64;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_CTRL_FRAG  = 3'd1;
   localparam logic [2:0] ERR_RSV_SET    = 3'd2;
   localparam logic [2:0] ERR_LEN_OVFL   = 3'd3;
   localparam logic [2:0] ERR_CTRL_LONG  = 3'd4;

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;
   localparam logic [LEN_REG_W-1:0] CTRL_MAX_LEN = LEN_REG_W'(125);

   localparam logic [2:0] EXT16_BYTES = 3'd2;
   localparam logic [2:0] EXT64_BYTES = 3'd0;
   localparam logic [2:0] KEY_BYTES   = 3'd4;

   typedef struct packed {
      logic [1:0]             kind;
      logic [3:0]             opcode;
      logic                   fin;
      logic                   masked;
      logic [LENGTH_BITS-1:0] frame_length;
      logic [7:0]             payload_byte;
      logic                   last;
      logic [2:0]             error_code;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
   } byte_req_type;

endpackage

`default_nettype wire

FILE: src/wsfd_in_stage.sv
// Input register stage for the incoming byte stream.
`default_nettype none

module wsfd_in_stage
   import wsfd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_data_byte,
   input  wire logic         step,
   output byte_req_type      held
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       take;

   assign req_ready = !valid_ff || step;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req_data_byte;
      end else if (step) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign held.valid     = valid_ff;
   assign held.data_byte = byte_ff;

endmodule

`default_nettype wire

FILE: src/wsfd_parser.sv
// Frame header parser, length checks and payload unmasking.
`default_nettype none

module wsfd_parser
   import wsfd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire byte_req_type held,
   output logic              res_valid,
   output result_type        res
);

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_SECOND,
      PH_LEN16,
      PH_LEN64,
      PH_KEY,
      PH_DATA
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [3:0]             opcode_ff, opcode_in;
   logic                   fin_ff, fin_in;
   logic                   mask_ff, mask_in;
   logic [LEN_REG_W-1:0]   length_ff, length_in;
   logic [2:0]             hcnt_ff, hcnt_in;
   logic [31:0]            key_ff, key_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;

   logic       len_done;
   logic       hdr_emit;
   logic [2:0] err;
   logic [7:0] b;
   logic [7:0] key_byte;
   logic       last_data;

   assign b = held.data_byte;

   always_comb begin
      case (count_ff[1:0])
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      fin_in    = fin_ff;
      mask_in   = mask_ff;
      length_in = length_ff;
      hcnt_in   = hcnt_ff;
      key_in    = key_ff;
      count_in  = count_ff;
      len_done  = 1'b0;
      hdr_emit  = 1'b0;
      err       = ERR_NONE;
      last_data = 1'b0;
      res_valid = 1'b0;
      res       = '0;

      case (phase_ff)
         PH_SECOND: begin
            mask_in   = b[7];
            length_in = '0;
            hcnt_in   = '0;
            if (b[6:0] == LEN7_EXT16) begin
               phase_in = PH_LEN16;
            end else if (b[6:0] == LEN7_EXT64) begin
               phase_in = PH_LEN64;
            end else begin
               length_in = LEN_REG_W'(b[6:0]);
               len_done  = 1'b1;
            end
         end
         PH_LEN16, PH_LEN64: begin
            length_in = {length_ff[LEN_REG_W-9:0], b};
            hcnt_in   = hcnt_ff + 3'd1;
            if ((phase_ff == PH_LEN16 && hcnt_in == EXT16_BYTES) ||
                (phase_ff == PH_LEN64 && hcnt_in == EXT64_BYTES)) begin
               len_done = 1'b1;
            end
         end
         PH_KEY: begin
            key_in  = {key_ff[23:0], b};
            hcnt_in = hcnt_ff + 3'd1;
            if (hcnt_in == KEY_BYTES) begin
               hdr_emit = 1'b1;
            end
         end
         PH_DATA: begin
            count_in  = count_ff + LENGTH_BITS'(1);
            last_data = (count_in >= length_ff[LENGTH_BITS-1:0]);
            res_valid = 1'b1;
            res.kind         = KIND_PAYLOAD;
            res.opcode       = opcode_ff;
            res.fin          = fin_ff;
            res.masked       = mask_ff;
            res.frame_length = length_ff[LENGTH_BITS-1:0];
            res.payload_byte = mask_ff ? (b ^ key_byte) : b;
            res.last         = last_data;
            res.error_code   = ERR_NONE;
            if (last_data) begin
               phase_in = PH_FIRST;
            end
         end
         default: begin
            opcode_in = b[3:0];
            fin_in    = b[7];
            mask_in   = 1'b0;
            length_in = '0;
            hcnt_in   = '0;
            if (b[3] && !b[7]) begin
               err = ERR_CTRL_FRAG;
            end else if (b[6:4] != 3'd0) begin
               err = ERR_RSV_SET;
            end else begin
               phase_in = PH_SECOND;
            end
         end
      endcase

      if (len_done) begin
         if ((length_in >> LENGTH_BITS) != '0) begin
            err = ERR_LEN_OVFL;
         end else if (opcode_ff[3] && length_in > CTRL_MAX_LEN) begin
            err = ERR_CTRL_LONG;
         end else if (mask_in) begin
            hcnt_in  = '0;
            key_in   = '0;
            phase_in = PH_KEY;
         end else begin
            hdr_emit = 1'b1;
         end
      end

      if (hdr_emit) begin
         count_in  = '0;
         phase_in  = (length_in == '0) ? PH_FIRST : PH_DATA;
         res_valid = 1'b1;
         res.kind         = KIND_HEADER;
         res.opcode       = opcode_in;
         res.fin          = fin_in;
         res.masked       = mask_in;
         res.frame_length = length_in[LENGTH_BITS-1:0];
         res.payload_byte = '0;
         res.last         = (length_in == '0);
         res.error_code   = ERR_NONE;
      end

      if (err != ERR_NONE) begin
         phase_in  = PH_FIRST;
         res_valid = 1'b1;
         res.kind         = KIND_ERROR;
         res.opcode       = opcode_in;
         res.fin          = fin_in;
         res.masked       = mask_in;
         res.frame_length = '0;
         res.payload_byte = '0;
         res.last         = 1'b1;
         res.error_code   = err;
      end

      if (!step) begin
         res_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
      end else if (step) begin
         phase_ff <= phase_in;
      end
      if (step) begin
         opcode_ff <= opcode_in;
         fin_ff    <= fin_in;
         mask_ff   <= mask_in;
         length_ff <= length_in;
         hcnt_ff   <= hcnt_in;
         key_ff    <= key_in;
         count_ff  <= count_in;
      end
   end

   // payload counter never reaches the frame length while data is due
   a_count_below_len: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> count_ff < length_ff[LENGTH_BITS-1:0])
      else $error("payload count reached frame length in data phase");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.kind == KIND_ERROR |-> res.last && res.frame_length == '0)
      else $error("error result without last or with a length");

   a_result_needs_step: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> step && held.valid)
      else $error("result raised without a held request");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.last |=> phase_ff == PH_FIRST)
      else $error("frame ended but parser not waiting for a new frame");

endmodule

`default_nettype wire

FILE: src/wsfd_out_stage.sv
// Result register for the response channel.
`default_nettype none

module wsfd_out_stage
   import wsfd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire result_type res,
   output logic            free,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output result_type      rsp
);

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;
   result_type res_in;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (free) begin
         valid_in = load;
      end
      if (load) begin
         res_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = res_ff;

endmodule

`default_nettype wire

FILE: src/websocket_frame_deframer_unit.sv
// Top level: websocket frame deframer, one stream byte per request.
// Path: an accepted request is registered in the input stage; the parser's result is registered in the output stage.
// Throughput: one byte per cycle, sustained while the response side keeps up.
// A byte that ends no header, raises no error and is not payload produces no response.
// Reset: synchronous; both stage registers empty, parser waits for a first byte.
`default_nettype none

module websocket_frame_deframer_unit
   import wsfd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [7:0]             req_data_byte,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [1:0]                  rsp_kind,
   output logic [3:0]                  rsp_opcode,
   output logic                        rsp_fin,
   output logic                        rsp_masked,
   output logic [LENGTH_BITS-1:0]      rsp_frame_length,
   output logic [7:0]                  rsp_payload_byte,
   output logic                        rsp_last,
   output logic [2:0]                  rsp_error_code
);

   byte_req_type held;
   result_type   res;
   result_type   rsp;
   logic         res_valid;
   logic         out_free;
   logic         step;

   assign step = held.valid && out_free;

   wsfd_in_stage u_in (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .step          (step),
      .held          (held)
   );

   wsfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .held      (held),
      .res_valid (res_valid),
      .res       (res)
   );

   wsfd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .res       (res),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_kind         = rsp.kind;
   assign rsp_opcode       = rsp.opcode;
   assign rsp_fin          = rsp.fin;
   assign rsp_masked       = rsp.masked;
   assign rsp_frame_length = rsp.frame_length;
   assign rsp_payload_byte = rsp.payload_byte;
   assign rsp_last         = rsp.last;
   assign rsp_error_code   = rsp.error_code;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the websocket frame deframer: frame stream stimulus and scoreboard.
`default_nettype none

import wsfd_pkg::*;

typedef enum logic [2:0] {
   PH_FIRST, PH_SECOND, PH_EXT16, PH_EXT64, PH_KEY, PH_PAYLOAD
} parse_phase_type;

typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} length_form_type;

class deframe_scoreboard;
   parse_phase_type  state;
   logic [3:0]       opc;
   logic             fin_f;
   logic             mask_f;
   logic [63:0]      len;
   int               hdr_count;
   logic [31:0]      key;
   logic [63:0]      pcount;
   result_type       expected_results[$];
   int               errors;
   int               checked;
   int               n_headers;
   int               n_payload;
   int               n_errors;

   function new();
      state = PH_FIRST;
      opc = '0;
      fin_f = 1'b0;
      mask_f = 1'b0;
      len = '0;
      hdr_count = 0;
      key = '0;
      pcount = '0;
      errors = 0;
      checked = 0;
      n_headers = 0;
      n_payload = 0;
      n_errors = 0;
   endfunction

   function int pending();
      return expected_results.size();
   endfunction

   function result_type make_result(logic [1:0] kind, logic [63:0] flen, logic [7:0] pbyte,
                                    logic last, logic [2:0] err);
      result_type r;
      r.kind         = kind;
      r.opcode       = opc;
      r.fin          = fin_f;
      r.masked       = mask_f;
      r.frame_length = flen[LENGTH_BITS-1:0];
      r.payload_byte = pbyte;
      r.last         = last;
      r.error_code   = err;
      return r;
   endfunction

   function void fail(logic [2:0] err);
      expected_results.push_back(make_result(KIND_ERROR, '0, '0, 1'b1, err));
      state = PH_FIRST;
   endfunction

   function void emit_header();
      expected_results.push_back(make_result(KIND_HEADER, len, '0, len == 0, ERR_NONE));
      pcount = '0;
      state = (len == 0) ? PH_FIRST : PH_PAYLOAD;
   endfunction

   function void length_done();
      if (len[63])
         fail(ERR_LEN_OVFL);
      else if (opc[3] && len > CTRL_MAX_LEN)
         fail(ERR_CTRL_LONG);
      else if (mask_f) begin
         hdr_count = 0;
         key = '0;
         state = PH_KEY;
      end else
         emit_header();
   endfunction

   // advance the parser by one accepted request
   function void note_byte(logic [7:0] b);
      logic [7:0] v;
      logic       last;
      int         idx;
      case (state)
         PH_SECOND: begin
            mask_f = b[7];
            len = '0;
            hdr_count = 0;
            if (b[6:0] == LEN7_EXT16)
               state = PH_EXT16;
            else if (b[6:0] == LEN7_EXT64)
               state = PH_EXT64;
            else begin
               len = 64'(b[6:0]);
               length_done();
            end
         end
         PH_EXT16, PH_EXT64: begin
            len = {len[55:0], b};
            hdr_count++;
            if (hdr_count == ((state == PH_EXT16) ? 2 : 8))
               length_done();
         end
         PH_KEY: begin
            key = {key[23:0], b};
            hdr_count++;
            if (hdr_count == 4)
               emit_header();
         end
         PH_PAYLOAD: begin
            v = b;
            if (mask_f) begin
               idx = 3 - int'(pcount[1:0]);
               v = v ^ key[idx*8 +: 8];
            end
            pcount++;
            last = (pcount >= len);
            expected_results.push_back(make_result(KIND_PAYLOAD, len, v, last, ERR_NONE));
            if (last)
               state = PH_FIRST;
         end
         default: begin
            opc = b[3:0];
            fin_f = b[7];
            mask_f = 1'b0;
            len = '0;
            hdr_count = 0;
            if (b[3] && !b[7])
               fail(ERR_CTRL_FRAG);
            else if (b[6:4] != 3'b000)
               fail(ERR_RSV_SET);
            else
               state = PH_SECOND;
         end
      endcase
   endfunction

   task report(string msg);
      errors++;
      if (errors <= 100)
         $display("MISMATCH response %0d: %s", checked, msg);
   endtask

   task compare(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
         report($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   task check_result(result_type got);
      result_type want;
      if (expected_results.size() == 0) begin
         report("response with no request awaiting it");
         return;
      end
      want = expected_results.pop_front();
      checked++;
      compare("kind", 64'(got.kind), 64'(want.kind));
      compare("opcode", 64'(got.opcode), 64'(want.opcode));
      compare("fin", 64'(got.fin), 64'(want.fin));
      compare("masked", 64'(got.masked), 64'(want.masked));
      compare("frame_length", 64'(got.frame_length), 64'(want.frame_length));
      compare("payload_byte", 64'(got.payload_byte), 64'(want.payload_byte));
      compare("last", 64'(got.last), 64'(want.last));
      compare("error_code", 64'(got.error_code), 64'(want.error_code));
      if (want.kind == KIND_HEADER)
         n_headers++;
      else if (want.kind == KIND_PAYLOAD)
         n_payload++;
      else
         n_errors++;
   endtask
endclass

module tb;
   localparam int HALF_PERIOD  = 6;
   localparam int LIMIT_CYCLES = 300000;
   localparam int RANDOM_ITEMS = 950;
   localparam int DRAIN_CYCLES = 8;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [7:0]             req_data_byte;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [1:0]             rsp_kind;
   logic [3:0]             rsp_opcode;
   logic                   rsp_fin;
   logic                   rsp_masked;
   logic [LENGTH_BITS-1:0] rsp_frame_length;
   logic [7:0]             rsp_payload_byte;
   logic                   rsp_last;
   logic [2:0]             rsp_error_code;

   deframe_scoreboard sb;
   logic [7:0]        stream_q[$];
   int                bytes_taken;
   logic              calm;
   bit                paused;

   // empty text, masked binary of two, non-final ping, reserved bits, all-ones byte,
   // ping of 126 via 16-bit length, 64-bit length with top bit set
   logic [7:0] directed_seq[27] = '{
      8'h81, 8'h00,
      8'h82, 8'h82, 8'hA5, 8'h5A, 8'hFF, 8'h00, 8'hFF, 8'h00,
      8'h09, 8'h70, 8'hFF,
      8'h89, 8'h7E, 8'h00, 8'h7E,
      8'h02, 8'h7F, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01
   };

   websocket_frame_deframer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_opcode       (rsp_opcode),
      .rsp_fin          (rsp_fin),
      .rsp_masked       (rsp_masked),
      .rsp_frame_length (rsp_frame_length),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last),
      .rsp_error_code   (rsp_error_code)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   assign calm = (bytes_taken >= 300) && (bytes_taken < 450);

   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 14);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_result(result_type'({rsp_kind, rsp_opcode, rsp_fin, rsp_masked,
                                          rsp_frame_length, rsp_payload_byte, rsp_last,
                                          rsp_error_code}));
         if (req_valid && req_ready) begin
            sb.note_byte(req_data_byte);
            bytes_taken <= bytes_taken + 1;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while (!calm && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (sb.pending() != 0);
   endtask

   task automatic build_frame(input logic [7:0] first, input logic mask_b,
                              input logic [63:0] n, input length_form_type form,
                              input bit header_only);
      stream_q.push_back(first);
      case (form)
         FORM_SHORT: stream_q.push_back({mask_b, n[6:0]});
         FORM_EXT16: begin
            stream_q.push_back({mask_b, LEN7_EXT16});
            stream_q.push_back(n[15:8]);
            stream_q.push_back(n[7:0]);
         end
         default: begin
            stream_q.push_back({mask_b, LEN7_EXT64});
            for (int i = 7; i >= 0; i--)
               stream_q.push_back(n[8*i +: 8]);
         end
      endcase
      if (!header_only) begin
         if (mask_b)
            repeat (4) stream_q.push_back(8'($urandom));
         repeat (int'(n)) stream_q.push_back(8'($urandom));
      end
   endtask

   task automatic rand_frame();
      int              r;
      int              s;
      logic            ctl;
      logic            fin_b;
      logic            mask_b;
      logic [63:0]     n;
      logic [7:0]      b;
      length_form_type form;
      r      = $urandom_range(99);
      s      = $urandom_range(9);
      ctl    = ($urandom_range(2) == 0);
      mask_b = 1'($urandom_range(1));
      form   = FORM_SHORT;
      if (s >= 8)
         form = FORM_EXT64;
      else if (s >= 6)
         form = FORM_EXT16;
      if (r < 62) begin
         fin_b = ctl ? 1'b1 : 1'($urandom_range(1));
         n = ($urandom_range(9) == 0) ? 64'($urandom_range(125)) : 64'($urandom_range(12));
         if (!ctl && form != FORM_SHORT && $urandom_range(3) == 0)
            n = 64'($urandom_range(300));
         build_frame({fin_b, 3'b000, ctl, 3'($urandom_range(7))}, mask_b, n, form, 1'b0);
      end else if (r < 70) begin
         b = 8'($urandom);
         b[7] = 1'b0;
         b[3] = 1'b1;
         stream_q.push_back(b);
      end else if (r < 80) begin
         b = 8'($urandom);
         if (b[6:4] == 3'b000)
            b[4 + $urandom_range(2)] = 1'b1;
         stream_q.push_back(b);
      end else if (r < 88) begin
         build_frame({1'b1, 3'b000, 1'b1, 3'($urandom_range(7))}, mask_b,
                     64'($urandom_range(1000, 126)),
                     (form == FORM_SHORT) ? FORM_EXT16 : form, 1'b1);
      end else begin
         n = {1'b1, 31'($urandom), 32'($urandom)};
         build_frame({1'b1, 3'b000, ctl, 3'($urandom_range(7))}, mask_b, n, FORM_EXT64, 1'b1);
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = '0;
      rsp_ready     = 1'b0;
      bytes_taken   = 0;
      paused        = 1'b0;
      sb            = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed_seq[i])
         send_byte(directed_seq[i]);
      wait_results_drained();
      while (bytes_taken < $size(directed_seq) + RANDOM_ITEMS) begin
         rand_frame();
         while (stream_q.size() != 0)
            send_byte(stream_q.pop_front());
         // hold requests back once until the block has emptied
         if (!paused && bytes_taken > $size(directed_seq) + RANDOM_ITEMS / 2) begin
            wait_results_drained();
            paused = 1'b1;
         end
      end
      wait_results_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Stream of %0d bytes: %0d headers, %0d payload bytes, %0d error responses",
               bytes_taken, sb.n_headers, sb.n_payload, sb.n_errors);
      $display("Random frames with both stall patterns, one drain pause; %0d mismatches",
               sb.errors);
      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * 2 * HALF_PERIOD);
      $display("Timed out with %0d responses outstanding", sb.pending());
      $display("== FAIL ==");
      $finish;
   end
endmodule

`default_nettype wire
